// File: sv/alle_pkg.sv
// shared types and constants of the array linked list engine
`timescale 1ns / 1ps
package alle_pkg;

	localparam int KEY_W = 56;
	localparam int S_DATA_W = 2 * KEY_W;
	localparam int M_DATA_W = 8;

	localparam logic [KEY_W-1:0] HEAD_KEY_RESET = KEY_W'(64'h0000_0000_4845_4144);

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
	localparam logic [1:0] STATUS_MISSING = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WSTART,
		ST_WALK,
		ST_INS_A,
		ST_INS_B,
		ST_DEL,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic start;
		logic take;
		logic drop;
	} scan_cmd_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_rsp_t;

endpackage

// File: sv/alle_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module alle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/alle_free.sv
// slot occupancy flags and the lowest free slot scan
`timescale 1ns / 1ps
module alle_free import alle_pkg::*; #(
	parameter int NODES = 16,
	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  scan_cmd_t     cmd,
	input  logic [IW-1:0] rel_idx,
	output scan_rsp_t     rsp,
	output logic [IW-1:0] free_idx
);

	localparam logic [IW-1:0] LAST = IW'(NODES - 1);

	logic [NODES-1:0] used_q;
	logic [IW-1:0]    idx_q;
	logic             busy_q;

	assign rsp.found = busy_q && !used_q[idx_q];
	assign rsp.done  = busy_q && (!used_q[idx_q] || idx_q == LAST);
	assign free_idx  = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= NODES'(1);
			idx_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				busy_q <= 1'b1;
				idx_q  <= IW'(1);
			end else if (busy_q) begin
				if (rsp.done) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.take) begin
				used_q[idx_q] <= 1'b1;
			end
			if (cmd.drop) begin
				used_q[rel_idx] <= 1'b0;
			end
		end
	end

	a_head_used: assert property (@(posedge clk) disable iff (!arst_n)
		used_q[0])
		else $error("head slot marked free");
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !busy_q && idx_q != '0 && !used_q[idx_q])
		else $error("allocating a slot that is not free");
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> busy_q && idx_q == IW'(1))
		else $error("scan did not start at slot one");

endmodule

// File: sv/array_linked_list_engine_core.sv
// top level of the array linked list engine
`timescale 1ns / 1ps
// Keyed singly linked list in a table of NODES slots, slot 0 being the head
// node. An input word with tuser 0 inserts new_key after the first node whose
// key equals anchor_key (or first in the list when only head_key matches);
// tuser 1 unlinks the first node whose key equals anchor_key. Each word yields
// one result word with status and slot. One operation is in work at a time:
// an insert is accepted, scans the occupancy flags for the lowest free slot,
// reads the first node, walks the list one visited node per read of the key
// and link memories (one read per cycle), writes the new node and, when it
// follows a node, that node's link, and then yields its result; a delete
// skips the scan. A finished result waits in the output register while the
// next word is taken. No clearing pass follows reset.
module array_linked_list_engine_core import alle_pkg::*; #(
	parameter int NODES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,   // new_key, anchor_key
	input  logic [0:0]          s_axis_tuser,   // action
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,   // status, slot, zero pad
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [KEY_W-1:0]    cfg_data        // head_key
);

	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int EW = (IW > 4) ? IW : 4;

	state_t state_q, state_nxt;

	logic [KEY_W-1:0] head_key_q;
	logic [IW-1:0]    head_link_q;
	logic             op_q;
	logic [KEY_W-1:0] new_key_q;
	logic [KEY_W-1:0] anchor_q;
	logic [IW-1:0]    cur_q;
	logic [IW-1:0]    prev_q;
	logic [IW-1:0]    hit_q;
	logic [IW-1:0]    nxt_q;
	logic [1:0]       res_status_q;
	logic [IW-1:0]    res_slot_q;
	logic             m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;

	logic             in_acc;
	logic             out_free;
	logic             walk_match;
	logic             walk_end;
	logic             ins_head;
	logic [EW-1:0]    slot_ext;

	logic             rd_en;
	logic [IW-1:0]    rd_addr;
	logic [KEY_W-1:0] key_rdata;
	logic [IW-1:0]    link_rdata;
	logic             key_we;
	logic             link_we;
	logic [IW-1:0]    link_waddr;
	logic [IW-1:0]    link_wdata;

	scan_cmd_t        scan_cmd;
	scan_rsp_t        scan_rsp;
	logic [IW-1:0]    free_idx;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign cfg_ready     = 1'b1;

	assign walk_match = (key_rdata == anchor_q);
	assign walk_end   = (link_rdata == '0);
	assign ins_head   = (op_q == ACT_INSERT) && (anchor_q == head_key_q);
	assign slot_ext   = EW'(res_slot_q);

	alle_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (free_idx),
		.wdata (new_key_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	alle_ram #(.WIDTH(IW), .DEPTH(NODES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	alle_free #(.NODES(NODES)) u_free (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (scan_cmd),
		.rel_idx  (hit_q),
		.rsp      (scan_rsp),
		.free_idx (free_idx)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_nxt = (s_axis_tuser[0] == ACT_DELETE) ? ST_WSTART : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_rsp.done) begin
					state_nxt = scan_rsp.found ? ST_WSTART : ST_RESP;
				end
			end
			ST_WSTART: begin
				if (head_link_q == '0) begin
					state_nxt = ins_head ? ST_INS_A : ST_RESP;
				end else begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_match) begin
					state_nxt = (op_q == ACT_INSERT) ? ST_INS_A : ST_DEL;
				end else if (walk_end) begin
					state_nxt = ins_head ? ST_INS_A : ST_RESP;
				end
			end
			ST_INS_A: state_nxt = (hit_q == '0) ? ST_RESP : ST_INS_B;
			ST_INS_B: state_nxt = ST_RESP;
			ST_DEL:   state_nxt = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en          = 1'b0;
		rd_addr        = head_link_q;
		key_we         = 1'b0;
		link_we        = 1'b0;
		link_waddr     = free_idx;
		link_wdata     = nxt_q;
		scan_cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				scan_cmd.start = in_acc && (s_axis_tuser[0] == ACT_INSERT);
			end
			ST_WSTART: begin
				rd_en = (head_link_q != '0);
			end
			ST_WALK: begin
				rd_en   = !walk_match && !walk_end;
				rd_addr = link_rdata;
			end
			ST_INS_A: begin
				key_we        = 1'b1;
				link_we       = 1'b1;
				scan_cmd.take = 1'b1;
			end
			ST_INS_B: begin
				link_we    = 1'b1;
				link_waddr = hit_q;
				link_wdata = free_idx;
			end
			ST_DEL: begin
				link_we       = (prev_q != '0);
				link_waddr    = prev_q;
				scan_cmd.drop = 1'b1;
			end
			ST_SCAN, ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_key_q  <= HEAD_KEY_RESET;
			head_link_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) begin
				head_key_q <= cfg_data;
			end
			if (state_q == ST_INS_A && hit_q == '0) begin
				head_link_q <= free_idx;
			end else if (state_q == ST_DEL && prev_q == '0) begin
				head_link_q <= nxt_q;
			end
			if (state_q == ST_RESP && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q      <= s_axis_tuser[0];
			new_key_q <= s_axis_tdata[KEY_W-1:0];
			anchor_q  <= s_axis_tdata[S_DATA_W-1:KEY_W];
		end
		unique case (state_q)
			ST_SCAN: begin
				if (scan_rsp.done && !scan_rsp.found) begin
					res_status_q <= STATUS_NO_SLOT;
					res_slot_q   <= '0;
				end
			end
			ST_WSTART: begin
				prev_q       <= '0;
				cur_q        <= head_link_q;
				hit_q        <= '0;
				nxt_q        <= head_link_q;
				res_status_q <= STATUS_MISSING;
				res_slot_q   <= '0;
			end
			ST_WALK: begin
				if (walk_match) begin
					hit_q <= cur_q;
					nxt_q <= link_rdata;
				end else if (walk_end) begin
					hit_q <= '0;
					nxt_q <= head_link_q;
				end else begin
					prev_q <= cur_q;
					cur_q  <= link_rdata;
				end
			end
			ST_INS_A: begin
				res_status_q <= STATUS_OK;
				res_slot_q   <= free_idx;
			end
			ST_DEL: begin
				res_status_q <= STATUS_OK;
				res_slot_q   <= hit_q;
			end
			ST_IDLE, ST_INS_B, ST_RESP: begin
			end
			default: begin
			end
		endcase
		if (state_q == ST_RESP && out_free) begin
			m_data_q <= {2'b00, slot_ext[3:0], res_status_q};
		end
	end

	a_walk_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> $past(rd_en))
		else $error("walk compare without a read issued");
	a_key_not_head: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> free_idx != '0)
		else $error("key written into the head slot");
	a_link_not_head: assert property (@(posedge clk) disable iff (!arst_n)
		link_we |-> link_waddr != '0)
		else $error("head link written into memory");
	a_drop_not_head: assert property (@(posedge clk) disable iff (!arst_n)
		scan_cmd.drop |-> hit_q != '0)
		else $error("head slot released");

endmodule
